/* hw/rtl/stc_pkg.sv */
// ---------------------------------------------------------------------------
// stc_pkg: shared types and constants for the stereo shelf tone control
// Field widths, register indexes, phase codes and the sequencer-to-lane
// control struct.
// ---------------------------------------------------------------------------
package stc_pkg;

  // Fixed field widths
  localparam int COEF_W     = 26;
  localparam int CFG_W      = 52;
  localparam int VOL_W      = 17;
  localparam int SAMPLE_W   = 32;
  localparam int OUT_W      = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_LANES  = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  // Parameter defaults
  localparam int DEF_COEF_FRAC_BITS = 23;
  localparam int DEF_HISTORY_WIDTH  = 40;

  // Operand split: low chunk is unsigned, padded to one signed chunk width
  localparam int LO_CHUNK_W = 24;
  localparam int CHUNK_W    = LO_CHUNK_W + 1;
  localparam int VOL_FRAC   = 16;

  // Schedule: two partial products per term, followed by a pipeline drain
  localparam int BQ_ISSUE      = 10;
  localparam int VOL_ISSUE     = 2;
  localparam int PHASE_BQ_LEN  = BQ_ISSUE + 2;
  localparam int PHASE_VOL_LEN = VOL_ISSUE + 2;
  localparam int CNT_LAST      = 2 * PHASE_BQ_LEN + PHASE_VOL_LEN - 1;
  localparam int CNT_W         = 5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BASS_B0_B1   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASS_B2_A1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASS_A2      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TREBLE_B0_B1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TREBLE_B2_A1 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TREBLE_A2    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_VOLUME       = 3'd6;

  // Processing phases
  localparam logic [1:0] PH_BASS   = 2'd0;
  localparam logic [1:0] PH_TREBLE = 2'd1;
  localparam logic [1:0] PH_VOL    = 2'd2;

  // Term indexes within a biquad
  localparam logic [2:0] TERM_X  = 3'd0;
  localparam logic [2:0] TERM_X1 = 3'd1;
  localparam logic [2:0] TERM_X2 = 3'd2;
  localparam logic [2:0] TERM_Y1 = 3'd3;
  localparam logic [2:0] TERM_Y2 = 3'd4;

  // Control from the sequencer, common to all lanes
  typedef struct packed {
    logic              load;
    logic [1:0]        phase;
    logic [2:0]        term;
    logic              mul_hi;
    logic [COEF_W-1:0] coef;
    logic              acc_first;
    logic              acc_hi;
    logic              fin;
  } lane_ctl_t;

endpackage

/* hw/rtl/stc_ctrl.sv */
// ---------------------------------------------------------------------------
// stc_ctrl: register file and sequencer
// Holds the coefficient and volume registers, steps the multiply-accumulate
// schedule and selects the coefficient shared by both lanes.
// ---------------------------------------------------------------------------
module stc_ctrl
  import stc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_fire,
  input  logic                  push_ok,
  output logic                  in_ready,
  output logic                  push,
  output lane_ctl_t             ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [CFG_W-1:0]  bass_b0_b1_r, bass_b2_a1_r, treble_b0_b1_r, treble_b2_a1_r;
  logic [COEF_W-1:0] bass_a2_r, treble_a2_r;
  logic [VOL_W-1:0]  volume_r;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [1:0]       phase;
  logic [CNT_W-1:0] loc, n_issue;
  logic             running;
  logic [CFG_W-1:0] b01, b2a1;
  logic [COEF_W-1:0] a2, coef;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bass_b0_b1_r   <= CFG_W'(8388608);
      bass_b2_a1_r   <= '0;
      bass_a2_r      <= '0;
      treble_b0_b1_r <= CFG_W'(8388608);
      treble_b2_a1_r <= '0;
      treble_a2_r    <= '0;
      volume_r       <= VOL_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_BASS_B0_B1:   bass_b0_b1_r   <= cfg_wdata;
        REG_BASS_B2_A1:   bass_b2_a1_r   <= cfg_wdata;
        REG_BASS_A2:      bass_a2_r      <= cfg_wdata[COEF_W-1:0];
        REG_TREBLE_B0_B1: treble_b0_b1_r <= cfg_wdata;
        REG_TREBLE_B2_A1: treble_b2_a1_r <= cfg_wdata;
        REG_TREBLE_A2:    treble_a2_r    <= cfg_wdata[COEF_W-1:0];
        REG_VOLUME:       volume_r       <= cfg_wdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase and position within phase
  always_comb begin
    if (cnt_r < CNT_W'(PHASE_BQ_LEN)) begin
      phase = PH_BASS;
      loc   = cnt_r;
    end else if (cnt_r < CNT_W'(2 * PHASE_BQ_LEN)) begin
      phase = PH_TREBLE;
      loc   = cnt_r - CNT_W'(PHASE_BQ_LEN);
    end else begin
      phase = PH_VOL;
      loc   = cnt_r - CNT_W'(2 * PHASE_BQ_LEN);
    end
    n_issue = (phase == PH_VOL) ? CNT_W'(VOL_ISSUE) : CNT_W'(BQ_ISSUE);
  end

  // Coefficient select, shared by both lanes
  always_comb begin
    b01  = (phase == PH_TREBLE) ? treble_b0_b1_r : bass_b0_b1_r;
    b2a1 = (phase == PH_TREBLE) ? treble_b2_a1_r : bass_b2_a1_r;
    a2   = (phase == PH_TREBLE) ? treble_a2_r : bass_a2_r;
    case (loc[3:1])
      TERM_X:  coef = b01[COEF_W-1:0];
      TERM_X1: coef = b01[2*COEF_W-1:COEF_W];
      TERM_X2: coef = b2a1[COEF_W-1:0];
      TERM_Y1: coef = b2a1[2*COEF_W-1:COEF_W];
      default: coef = a2;
    endcase
    if (phase == PH_VOL) coef = {{(COEF_W-VOL_W){1'b0}}, volume_r};
  end

  // Lane control: issue at loc, accumulate the registered product in the next cycle, finish after that
  assign running = (state_r == ST_RUN);
  always_comb begin
    ctl.load      = in_fire;
    ctl.phase     = phase;
    ctl.term      = loc[3:1];
    ctl.mul_hi    = loc[0];
    ctl.coef      = coef;
    ctl.acc_first = (loc == CNT_W'(1));
    ctl.acc_hi    = ~loc[0];
    ctl.fin       = running && (loc == n_issue + CNT_W'(1));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_r == CNT_W'(CNT_LAST)) state_nxt = ST_PUSH;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_PUSH: begin
        if (push_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign push     = (state_r == ST_PUSH) && push_ok;

endmodule

/* hw/rtl/stc_lane.sv */
// ---------------------------------------------------------------------------
// stc_lane: one channel's filter core
// History registers, a 26x25 multiplier and an accumulator; runs the low
// shelf, high shelf and volume gain as a sequence of partial products.
// ---------------------------------------------------------------------------
module stc_lane
  import stc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int HISTORY_WIDTH  = DEF_HISTORY_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] x_in,
  output logic signed [OUT_W-1:0]    res
);

  localparam int HW     = HISTORY_WIDTH;
  localparam int HI_W   = HW - LO_CHUNK_W;
  localparam int PROD_W = COEF_W + CHUNK_W;
  localparam int ACC_W  = HW + COEF_W + 3;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [HW-1:0]       hist_r [8];
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [OUT_W-1:0]    res_r;

  logic signed [HW-1:0]      x_ext, src, y_bq;
  logic signed [CHUNK_W-1:0] chunk;
  logic signed [COEF_W-1:0]  coef_s;
  logic signed [ACC_W-1:0]   prod_ext, addend, sh_bq, sh_vol;
  logic signed [OUT_W-1:0]   y_out;

  assign x_ext = {{(HW-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};

  // Operand select for the current term
  always_comb begin
    case (ctl.phase)
      PH_BASS: begin
        case (ctl.term)
          TERM_X:  src = x_ext;
          TERM_X1: src = hist_r[0];
          TERM_X2: src = hist_r[1];
          TERM_Y1: src = hist_r[2];
          default: src = hist_r[3];
        endcase
      end
      PH_TREBLE: begin
        case (ctl.term)
          TERM_X:  src = hist_r[2];
          TERM_X1: src = hist_r[4];
          TERM_X2: src = hist_r[5];
          TERM_Y1: src = hist_r[6];
          default: src = hist_r[7];
        endcase
      end
      default: src = hist_r[6];
    endcase
  end

  // Low chunk unsigned, high chunk signed
  assign chunk  = ctl.mul_hi ? {{(CHUNK_W-HI_W){src[HW-1]}}, src[HW-1:LO_CHUNK_W]}
                             : {1'b0, src[LO_CHUNK_W-1:0]};
  assign coef_s = ctl.coef;
  assign prod_nxt = coef_s * chunk;

  // Accumulate registered partial products
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign addend   = ctl.acc_hi ? (prod_ext <<< LO_CHUNK_W) : prod_ext;
  assign acc_nxt  = (ctl.acc_first ? '0 : acc_r) + addend;

  // Floor shift and saturation of the finished sum
  assign sh_bq  = acc_r >>> COEF_FRAC_BITS;
  assign sh_vol = acc_r >>> VOL_FRAC;

  always_comb begin
    if ((&sh_bq[ACC_W-1:HW-1]) || !(|sh_bq[ACC_W-1:HW-1]))
      y_bq = sh_bq[HW-1:0];
    else
      y_bq = {sh_bq[ACC_W-1], {(HW-1){~sh_bq[ACC_W-1]}}};
    if ((&sh_vol[ACC_W-1:OUT_W-1]) || !(|sh_vol[ACC_W-1:OUT_W-1]))
      y_out = sh_vol[OUT_W-1:0];
    else
      y_out = {sh_vol[ACC_W-1], {(OUT_W-1){~sh_vol[ACC_W-1]}}};
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.load) x_r <= x_in;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctl.fin && ctl.phase == PH_VOL) res_r <= y_out;
  end

  // Filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hist_r[i] <= '0;
    end else if (ctl.fin) begin
      unique case (ctl.phase)
        PH_BASS: begin
          hist_r[0] <= x_ext;
          hist_r[1] <= hist_r[0];
          hist_r[2] <= y_bq;
          hist_r[3] <= hist_r[2];
        end
        PH_TREBLE: begin
          hist_r[4] <= hist_r[2];
          hist_r[5] <= hist_r[4];
          hist_r[6] <= y_bq;
          hist_r[7] <= hist_r[6];
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;

endmodule

/* hw/rtl/stc_merge.sv */
// ---------------------------------------------------------------------------
// stc_merge: output stage
// Packs the left and right lane results into one output beat and holds it
// until the downstream side takes it.
// ---------------------------------------------------------------------------
module stc_merge
  import stc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [OUT_W-1:0]        left_res,
  input  logic [OUT_W-1:0]        right_res,
  output logic                    push_ok,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;

  // Slot is free when empty or being drained this cycle
  assign push_ok = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (push) valid_r <= 1'b1;
    else if (out_tready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) data_r <= {{(OUT_TDATA_W-2*OUT_W){1'b0}}, right_res, left_res};
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* hw/rtl/stereo_shelf_tone_control_top.sv */
// ---------------------------------------------------------------------------
// stereo_shelf_tone_control_top: stereo bass/treble tone control with volume
// Two lanes, one per channel, each running a low shelf and a high shelf
// biquad and a volume gain on a shared coefficient sequencer.
// ---------------------------------------------------------------------------
// One input beat carries a stereo pair; one output beat comes back per input.
// An item is accepted, then runs through the multiply-accumulate schedule
// (each biquad is 5 terms x 2 partial products of a 26x25 multiplier plus a
// pipeline drain, the volume gain 2 products plus a drain), and its result is
// handed to the output register once the output side can take it. The next
// pair is accepted while a finished beat still waits.
// Coefficient writes belong between items, while the block is idle.
module stereo_shelf_tone_control_top
  import stc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int HISTORY_WIDTH  = DEF_HISTORY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // left_in [31:0], right_in [63:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // left_out [30:0], right_out [61:31]
);

  lane_ctl_t         ctl;
  logic              in_fire, push, push_ok;
  logic [OUT_W-1:0]  lane_res [NUM_LANES];

  assign in_fire = in_tvalid && in_tready;

  // Registers and sequencer
  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .push_ok   (push_ok),
    .in_ready  (in_tready),
    .push      (push),
    .ctl       (ctl)
  );

  // One lane per channel
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    stc_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .HISTORY_WIDTH  (HISTORY_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .x_in  (in_tdata[g*SAMPLE_W +: SAMPLE_W]),
      .res   (lane_res[g])
    );
  end

  // Output packing
  stc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .left_res   (lane_res[0]),
    .right_res  (lane_res[1]),
    .push_ok    (push_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
